@@ rtl/core/mbd_pkg.sv @@
package mbd_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_LEVEL_DEF = 8;

  localparam int CFG_DATA_W = 13;
  localparam int LEVEL_CFG_W = 4;
  localparam int PIX_W = 8;
  localparam int POS_OUT_W = 12;
  localparam int CHANNELS = 4;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RST = 13'd1;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 13'd1;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LEVEL  = 2'd2,
    REG_FORMAT = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    FMT_RGBA8 = 1'b0,
    FMT_RGB8  = 1'b1
  } pix_fmt_t;

  typedef struct packed {
    logic [PIX_W-1:0]     red;
    logic [PIX_W-1:0]     green;
    logic [PIX_W-1:0]     blue;
    logic [PIX_W-1:0]     alpha;
    logic [POS_OUT_W-1:0] col;
    logic [POS_OUT_W-1:0] row;
    logic                 last;
  } result_t;

endpackage

@@ rtl/core/mipmap_box_downsample.sv @@
// An output word is registered in the second stage and then in the output queue.
// Throughput: one source pixel per clock while the output queue has room; the per-column
// running sums sit in one synchronous row memory that is read at acceptance and written
// back the next cycle, with forwarding when neighboring pixels hit the same column entry.
// Reset clears configuration, raster position and the output queue; the row memory is
// not cleared, since each entry is written at the first pixel of its square.
module mipmap_box_downsample #(
  parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_LEVEL = mbd_pkg::MAX_LEVEL_DEF
) (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]      cfg_data,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mbd_pkg::PIX_W-1:0]           red,
  input  logic [mbd_pkg::PIX_W-1:0]           green,
  input  logic [mbd_pkg::PIX_W-1:0]           blue,
  input  logic [mbd_pkg::PIX_W-1:0]           alpha,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mbd_pkg::PIX_W-1:0]           out_red,
  output logic [mbd_pkg::PIX_W-1:0]           out_green,
  output logic [mbd_pkg::PIX_W-1:0]           out_blue,
  output logic [mbd_pkg::PIX_W-1:0]           out_alpha,
  output logic [mbd_pkg::POS_OUT_W-1:0]       out_col,
  output logic [mbd_pkg::POS_OUT_W-1:0]       out_row,
  output logic                                last_of_level
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW = COL_W + 1;
  localparam int ACC_DEPTH = MAX_WIDTH / 2;
  localparam int AW = $clog2(ACC_DEPTH);
  localparam int LV_W = $clog2(MAX_LEVEL + 1);
  localparam int SUM_W = mbd_pkg::PIX_W + 2 * MAX_LEVEL;
  localparam int NCH = mbd_pkg::CHANNELS;
  localparam int QDEPTH = 3;

  function automatic logic [WW-1:0] clamp_dim(input logic [mbd_pkg::CFG_DATA_W-1:0] v);
    logic [WW-1:0] res;
    if (v == '0) begin
      res = WW'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      res = WW'(MAX_WIDTH);
    end else begin
      res = WW'(v);
    end
    return res;
  endfunction

  // Configuration registers.
  logic [mbd_pkg::CFG_DATA_W-1:0]  cfg_width;
  logic [mbd_pkg::CFG_DATA_W-1:0]  cfg_height;
  logic [mbd_pkg::LEVEL_CFG_W-1:0] cfg_level;
  mbd_pkg::pix_fmt_t               cfg_format;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width <= mbd_pkg::WIDTH_RST;
      cfg_height <= mbd_pkg::HEIGHT_RST;
      cfg_level <= '0;
      cfg_format <= mbd_pkg::FMT_RGBA8;
    end else if (cfg_valid && cfg_ready) begin
      unique case (mbd_pkg::cfg_idx_t'(cfg_index))
        mbd_pkg::REG_WIDTH: begin
          cfg_width <= cfg_data;
        end
        mbd_pkg::REG_HEIGHT: begin
          cfg_height <= cfg_data;
        end
        mbd_pkg::REG_LEVEL: begin
          cfg_level <= cfg_data[mbd_pkg::LEVEL_CFG_W-1:0];
        end
        mbd_pkg::REG_FORMAT: begin
          cfg_format <= mbd_pkg::pix_fmt_t'(cfg_data[0]);
        end
      endcase
    end
  end

  // Derived geometry.
  logic [WW-1:0]   dim_w;
  logic [WW-1:0]   dim_h;
  logic [LV_W-1:0] lv;
  logic [WW-1:0]   w_out;
  logic [WW-1:0]   h_out;
  logic [COL_W-1:0] mask;

  always_comb begin
    dim_w = clamp_dim(cfg_width);
    dim_h = clamp_dim(cfg_height);
    if (int'(cfg_level) > MAX_LEVEL) begin
      lv = LV_W'(MAX_LEVEL);
    end else begin
      lv = LV_W'(cfg_level);
    end
    w_out = dim_w >> lv;
    h_out = dim_h >> lv;
    mask = COL_W'((WW'(1) << lv) - WW'(1));
  end

  // Raster position and per-pixel decode at acceptance.
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] row;
  logic [COL_W-1:0] col_next;
  logic [COL_W-1:0] row_next;
  logic [COL_W-1:0] row_eff;
  logic [WW-1:0]    col_inc;
  logic [WW-1:0]    row_inc;
  logic [COL_W-1:0] bx;
  logic [COL_W-1:0] by;
  logic             in_blk;
  logic             acc_ok;
  logic             px_first;
  logic             px_end;
  logic             px_wr;
  logic             px_emit;
  logic             px_last;
  logic [AW-1:0]    px_addr;
  logic             accept;

  always_comb begin
    row_eff = ({1'b0, row} >= dim_h) ? '0 : row;
    bx = col >> lv;
    by = row_eff >> lv;
    in_blk = ({1'b0, col} < dim_w) && ({1'b0, row_eff} < dim_h)
             && ({1'b0, bx} < w_out) && ({1'b0, by} < h_out);
    acc_ok = {1'b0, bx} < WW'(ACC_DEPTH);
    px_first = ((col & mask) == '0) && ((row_eff & mask) == '0);
    px_end = ((col & mask) == mask) && ((row_eff & mask) == mask);
    px_wr = in_blk && (lv != '0) && acc_ok;
    px_emit = in_blk && ((lv == '0) || (acc_ok && px_end));
    px_last = ({1'b0, bx} == w_out - WW'(1)) && ({1'b0, by} == h_out - WW'(1));
    px_addr = bx[AW-1:0];

    col_inc = {1'b0, col} + WW'(1);
    row_inc = {1'b0, row_eff} + WW'(1);
    if (col_inc >= dim_w) begin
      col_next = '0;
      row_next = (row_inc >= dim_h) ? '0 : row_inc[COL_W-1:0];
    end else begin
      col_next = col_inc[COL_W-1:0];
      row_next = row_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Row memory of running sums, all four channels side by side.
  logic [NCH*SUM_W-1:0] acc_mem [ACC_DEPTH];
  logic [NCH*SUM_W-1:0] acc_rd;
  logic [NCH*SUM_W-1:0] acc_wr;
  logic [NCH*SUM_W-1:0] fwd_data;

  // Second stage: the pixel whose memory read has just returned.
  logic                          s1_valid;
  logic                          s1_wr;
  logic                          s1_emit;
  logic                          s1_first;
  logic                          s1_fwd;
  logic                          s1_last;
  logic [AW-1:0]                 s1_addr;
  logic [LV_W-1:0]               s1_lv;
  logic [mbd_pkg::POS_OUT_W-1:0] s1_col;
  logic [mbd_pkg::POS_OUT_W-1:0] s1_row;
  logic [mbd_pkg::PIX_W-1:0]     s1_pix [NCH];
  logic [mbd_pkg::PIX_W-1:0]     alpha_eff;

  assign alpha_eff = (cfg_format == mbd_pkg::FMT_RGB8) ? mbd_pkg::PIX_MAX : alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_wr <= 1'b0;
      s1_emit <= 1'b0;
    end else begin
      s1_valid <= accept;
      s1_wr <= accept && px_wr;
      s1_emit <= accept && px_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      // The entry written this cycle by the previous pixel is not yet in the read data.
      s1_fwd <= s1_wr && (s1_addr == px_addr);
      s1_first <= px_first;
      s1_last <= px_last;
      s1_addr <= px_addr;
      s1_lv <= lv;
      s1_col <= mbd_pkg::POS_OUT_W'(bx);
      s1_row <= mbd_pkg::POS_OUT_W'(by);
      s1_pix[0] <= red;
      s1_pix[1] <= green;
      s1_pix[2] <= blue;
      s1_pix[3] <= alpha_eff;
    end
  end

  always_ff @(posedge clk) begin
    acc_rd <= acc_mem[px_addr];
    if (s1_wr) begin
      acc_mem[s1_addr] <= acc_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      fwd_data <= acc_wr;
    end
  end

  logic [NCH*SUM_W-1:0]      base;
  logic [SUM_W-1:0]          shifted [NCH];
  logic [mbd_pkg::PIX_W-1:0] avg [NCH];

  always_comb begin
    base = s1_fwd ? fwd_data : acc_rd;
    for (int k = 0; k < NCH; k++) begin
      if (s1_first) begin
        acc_wr[k*SUM_W +: SUM_W] = SUM_W'(s1_pix[k]);
      end else begin
        acc_wr[k*SUM_W +: SUM_W] = base[k*SUM_W +: SUM_W] + SUM_W'(s1_pix[k]);
      end
      shifted[k] = acc_wr[k*SUM_W +: SUM_W] >> {s1_lv, 1'b0};
      if (shifted[k] > SUM_W'(mbd_pkg::PIX_MAX)) begin
        avg[k] = mbd_pkg::PIX_MAX;
      end else begin
        avg[k] = shifted[k][mbd_pkg::PIX_W-1:0];
      end
    end
  end

  // Output queue: three words, so the input keeps flowing while a word waits.
  mbd_pkg::result_t q_mem [QDEPTH];
  mbd_pkg::result_t q_head;
  mbd_pkg::result_t s1_res;
  logic [1:0]       q_wr_ptr;
  logic [1:0]       q_rd_ptr;
  logic [1:0]       q_occ;
  logic             q_push;
  logic             q_pop;

  always_comb begin
    s1_res.red = avg[0];
    s1_res.green = avg[1];
    s1_res.blue = avg[2];
    s1_res.alpha = avg[3];
    s1_res.col = s1_col;
    s1_res.row = s1_row;
    s1_res.last = s1_last;
  end

  assign q_push = s1_valid && s1_emit;
  assign q_pop = out_valid && out_ready;
  // A pixel in the second stage may still add a word, so it holds a slot.
  assign in_ready = ({1'b0, q_occ} + {2'b00, s1_valid}) <= 3'd2;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr_ptr <= '0;
      q_rd_ptr <= '0;
      q_occ <= '0;
    end else begin
      if (q_push) begin
        q_wr_ptr <= (q_wr_ptr == 2'(QDEPTH - 1)) ? '0 : q_wr_ptr + 2'd1;
      end
      if (q_pop) begin
        q_rd_ptr <= (q_rd_ptr == 2'(QDEPTH - 1)) ? '0 : q_rd_ptr + 2'd1;
      end
      if (q_push && !q_pop) begin
        q_occ <= q_occ + 2'd1;
      end else if (q_pop && !q_push) begin
        q_occ <= q_occ - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wr_ptr] <= s1_res;
    end
  end

  assign q_head = q_mem[q_rd_ptr];
  assign out_valid = q_occ != '0;
  assign out_red = q_head.red;
  assign out_green = q_head.green;
  assign out_blue = q_head.blue;
  assign out_alpha = q_head.alpha;
  assign out_col = q_head.col;
  assign out_row = q_head.row;
  assign last_of_level = q_head.last;

endmodule

@@ bench/mipmap_box_downsample_tb.sv @@
`timescale 1ns / 100ps

module mipmap_box_downsample_tb;
  import mbd_pkg::*;

  localparam int SUM_DEPTH = MAX_WIDTH_DEF / 2;
  localparam int unsigned RAND_BUDGET = 540;
  localparam int unsigned CALM_FROM = 440;

  class box_average_board;
    logic [CFG_DATA_W-1:0]  width_reg;
    logic [CFG_DATA_W-1:0]  height_reg;
    logic [LEVEL_CFG_W-1:0] level_reg;
    pix_fmt_t               fmt_reg;
    int unsigned            col_sum [CHANNELS][SUM_DEPTH];
    int unsigned            col_pos;
    int unsigned            row_pos;
    result_t                awaited_pixels [$];
    int unsigned            accepted;
    int unsigned            checked;
    int unsigned            mismatches;

    function new();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      level_reg  = '0;
      fmt_reg    = FMT_RGBA8;
      col_pos    = 0;
      row_pos    = 0;
      accepted   = 0;
      checked    = 0;
      mismatches = 0;
      foreach (col_sum[k, i]) col_sum[k][i] = 0;
    endfunction

    function int unsigned clamp_size(logic [CFG_DATA_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return v;
    endfunction

    function logic [PIX_W-1:0] level_average(int unsigned sum, int unsigned lv);
      int unsigned v;
      v = sum >> (2 * lv);
      return (v > 255) ? PIX_MAX : v[PIX_W-1:0];
    endfunction

    function int pending();
      return awaited_pixels.size();
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WIDTH:  width_reg = data;
        REG_HEIGHT: height_reg = data;
        REG_LEVEL:  level_reg = data[LEVEL_CFG_W-1:0];
        REG_FORMAT: fmt_reg = pix_fmt_t'(data[0]);
        default: ;
      endcase
    endfunction

    function void note_source_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                    logic [PIX_W-1:0] b, logic [PIX_W-1:0] a);
      int unsigned w, h, lv, mask, w_out, h_out, c, rw, bx, by;
      int unsigned s [CHANNELS];
      logic [PIX_W-1:0] px [CHANNELS];
      bit emit;
      result_t e;
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      lv = (level_reg > MAX_LEVEL_DEF) ? MAX_LEVEL_DEF : level_reg;
      mask = (1 << lv) - 1;
      w_out = w >> lv;
      h_out = h >> lv;
      c = col_pos;
      rw = row_pos;
      px[0] = r;
      px[1] = g;
      px[2] = b;
      px[3] = (fmt_reg == FMT_RGB8) ? PIX_MAX : a;
      accepted++;
      // A row left past a shrunken height restarts at the top.
      if (rw >= h) rw = 0;
      if (c < w && (c >> lv) < w_out && (rw >> lv) < h_out) begin
        bx = c >> lv;
        by = rw >> lv;
        for (int k = 0; k < CHANNELS; k++) s[k] = px[k];
        if (lv == 0) begin
          emit = 1'b1;
        end else begin
          // The first pixel of a square starts its sum fresh.
          if ((c & mask) != 0 || (rw & mask) != 0) begin
            for (int k = 0; k < CHANNELS; k++) s[k] += col_sum[k][bx];
          end
          for (int k = 0; k < CHANNELS; k++) col_sum[k][bx] = s[k];
          emit = ((c & mask) == mask) && ((rw & mask) == mask);
        end
        if (emit) begin
          e.red   = level_average(s[0], lv);
          e.green = level_average(s[1], lv);
          e.blue  = level_average(s[2], lv);
          e.alpha = level_average(s[3], lv);
          e.col   = bx[POS_OUT_W-1:0];
          e.row   = by[POS_OUT_W-1:0];
          e.last  = (bx == w_out - 1) && (by == h_out - 1);
          awaited_pixels.push_back(e);
        end
      end
      c++;
      if (c >= w) begin
        c = 0;
        rw++;
        if (rw >= h) rw = 0;
      end
      col_pos = c;
      row_pos = rw;
    endfunction

    function void check_mip_pixel(result_t got);
      result_t e;
      checked++;
      if (awaited_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected output rgba %h %h %h %h at (%0d,%0d) last %b", $time,
                   got.red, got.green, got.blue, got.alpha, got.col, got.row, got.last);
        return;
      end
      e = awaited_pixels.pop_front();
      if (got.red !== e.red || got.green !== e.green || got.blue !== e.blue ||
          got.alpha !== e.alpha || got.col !== e.col || got.row !== e.row ||
          got.last !== e.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: expected rgba %h %h %h %h at (%0d,%0d) last %b", $time,
                   e.red, e.green, e.blue, e.alpha, e.col, e.row, e.last);
          $display("%0t:      got rgba %h %h %h %h at (%0d,%0d) last %b", $time,
                   got.red, got.green, got.blue, got.alpha, got.col, got.row, got.last);
        end
      end
    endfunction

    function void close_out();
      if (awaited_pixels.size() != 0) begin
        mismatches += awaited_pixels.size();
        $display("%0d expected output words never arrived", awaited_pixels.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [1:0]              cfg_index = REG_WIDTH;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [PIX_W-1:0]        red = '0;
  logic [PIX_W-1:0]        green = '0;
  logic [PIX_W-1:0]        blue = '0;
  logic [PIX_W-1:0]        alpha = '0;

  logic                    out_valid;
  logic                    out_ready = 1'b1;
  logic [PIX_W-1:0]        out_red;
  logic [PIX_W-1:0]        out_green;
  logic [PIX_W-1:0]        out_blue;
  logic [PIX_W-1:0]        out_alpha;
  logic [POS_OUT_W-1:0]    out_col;
  logic [POS_OUT_W-1:0]    out_row;
  logic                    last_of_level;

  box_average_board sb = new();

  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned stall_left = 0;
  int unsigned settings = 0;
  bit          calm = 1'b0;

  mipmap_box_downsample DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .alpha         (alpha),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .out_col       (out_col),
    .out_row       (out_row),
    .last_of_level (last_of_level)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver back-pressure in short random bursts.
  always @(negedge clk) begin
    if (stall_left == 0 && !calm && $urandom_range(0, 99) < out_stall_pct)
      stall_left = $urandom_range(1, 5);
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin : watch_output
    result_t word;
    if (!rst && out_valid && out_ready) begin
      word.red   = out_red;
      word.green = out_green;
      word.blue  = out_blue;
      word.alpha = out_alpha;
      word.col   = out_col;
      word.row   = out_row;
      word.last  = last_of_level;
      sb.check_mip_pixel(word);
    end
  end

  function automatic logic [PIX_W-1:0] chan_value();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return PIX_MAX;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // All drive tasks start and end just after a falling edge.
  task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] a);
    if (!calm && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid = 1'b1;
    red = r;
    green = g;
    blue = b;
    alpha = a;
    do @(posedge clk); while (!in_ready);
    sb.note_source_pixel(r, g, b, a);
    @(negedge clk);
  endtask

  task automatic send_random_pixels(input int unsigned n);
    repeat (n) send_pixel(chan_value(), chan_value(), chan_value(), chan_value());
  endtask

  // Also covers a word still in flight that produces no output.
  task automatic wait_drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_image(input int unsigned w, input int unsigned h,
                           input int unsigned lv, input pix_fmt_t fmt);
    wait_drain();
    cfg_write(REG_WIDTH, CFG_DATA_W'(w));
    cfg_write(REG_HEIGHT, CFG_DATA_W'(h));
    cfg_write(REG_LEVEL, CFG_DATA_W'(lv));
    cfg_write(REG_FORMAT, CFG_DATA_W'(fmt));
    cfg_valid = 1'b0;
    settings++;
  endtask

  // A 1x1 image at level 0 pulls the raster position back to the top-left
  // without touching the row sums.
  task automatic return_to_origin();
    if (sb.col_pos != 0 || sb.row_pos != 0) begin
      set_image(1, 1, 0, FMT_RGBA8);
      send_random_pixels(1);
    end
  endtask

  initial begin : stimulus
    logic [PIX_W-1:0] two_blocks [8];
    int unsigned rand_pixels, lv, w, h, total, pause_at;

    two_blocks = '{8'hFF, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'h80, 8'h7F};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset configuration passes single pixels straight through.
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX);
    send_pixel(8'hA5, 8'h5A, 8'hC3, 8'h3C);

    set_image(0, 0, 0, FMT_RGB8);
    send_pixel(8'h12, 8'h34, 8'h56, 8'h00);

    set_image(4, 2, 1, FMT_RGBA8);
    for (int i = 0; i < 8; i++) begin
      if (i == 4) wait_drain();
      send_pixel(two_blocks[i], 8'hFF - two_blocks[i], two_blocks[i] ^ 8'h0F, two_blocks[i]);
    end

    // Odd sizes leave a spare column and row.
    set_image(3, 3, 1, FMT_RGB8);
    send_random_pixels(9);

    // Square bigger than the image.
    set_image(1, 2, 8, FMT_RGBA8);
    send_random_pixels(2);

    // Size changes in the middle of an image, kept at level 0.
    in_idle_pct = 30;
    out_stall_pct = 30;
    set_image(6, 4, 0, FMT_RGBA8);
    send_random_pixels(9);
    wait_drain();
    cfg_write(REG_WIDTH, CFG_DATA_W'(2));
    cfg_valid = 1'b0;
    send_random_pixels(4);
    wait_drain();
    cfg_write(REG_HEIGHT, CFG_DATA_W'(1));
    cfg_valid = 1'b0;
    send_random_pixels(4);
    return_to_origin();

    // Oversized width, height and level registers, each cut short.
    in_idle_pct = 10;
    out_stall_pct = 10;
    set_image(13'h1FFF, 1, 0, FMT_RGBA8);
    send_random_pixels(40);
    return_to_origin();
    set_image(0, 13'h1FFF, 0, FMT_RGB8);
    send_random_pixels(40);
    return_to_origin();
    set_image(256, 256, 15, FMT_RGBA8);
    send_random_pixels(40);
    return_to_origin();

    rand_pixels = 0;
    while (rand_pixels < RAND_BUDGET) begin
      if (rand_pixels >= CALM_FROM) calm = 1'b1;
      case ($urandom_range(0, 2))
        0: in_idle_pct = 0;
        1: in_idle_pct = 15;
        default: in_idle_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: out_stall_pct = 0;
        1: out_stall_pct = 15;
        default: out_stall_pct = 40;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        lv = 4;
        w = 16 + $urandom_range(0, 2);
        h = 16 + $urandom_range(0, 1);
        total = w * h;
      end else begin
        lv = $urandom_range(0, 3);
        w = (1 << lv) * $urandom_range(1, 3) + $urandom_range(0, 2);
        h = (1 << lv) * $urandom_range(1, 2) + $urandom_range(0, 1);
        total = w * h * $urandom_range(1, 2);
      end
      set_image(w, h, lv, pix_fmt_t'($urandom_range(0, 1)));
      // Now and then an image is cut short.
      if (w * h > 1 && $urandom_range(0, 5) == 0) total = $urandom_range(1, w * h - 1);
      if (total > RAND_BUDGET - rand_pixels) total = RAND_BUDGET - rand_pixels;
      pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, total - 1) : total;
      for (int unsigned i = 0; i < total; i++) begin
        if (i == pause_at) wait_drain();
        send_pixel(chan_value(), chan_value(), chan_value(), chan_value());
      end
      rand_pixels += total;
      return_to_origin();
    end

    wait_drain();
    sb.close_out();
    $display("Checked %0d output words from %0d source pixels over %0d size/level settings,",
             sb.checked, sb.accepted, settings);
    $display("from 1x1 pass-through and clamped sizes to level 1-4 squares with spare edges.");
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
